@@ rtl/nfctr_pkg.sv @@
// Types, constants and a helper function shared by the target response parser.
package nfctr_pkg;

   localparam int POS_W = 8;
   localparam int UID_CAP = 7;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] HDR_FIRST = 8'hD5;
   localparam logic [7:0] HDR_SECOND = 8'h4B;
   localparam logic [POS_W-1:0] MIN_FRAME = POS_W'(10);

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_DISABLED = 3'd1;
   localparam logic [2:0] ST_SHORT = 3'd2;
   localparam logic [2:0] ST_NO_HEADER = 3'd3;
   localparam logic [2:0] ST_NO_TAG = 3'd4;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd5;
   localparam logic [2:0] ST_TRUNCATED = 3'd6;

   typedef struct packed {
      logic [7:0] resp_byte;
      logic last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] tag_count;
      logic [2:0] uid_length;
      logic [UID_CAP*8-1:0] uid_bytes;
   } rsp_type;

   typedef struct packed {
      logic enabled;
      logic [POS_W-1:0] len;
      logic header_found;
      logic [POS_W-1:0] header_start;
      logic [7:0] count_byte;
      logic [7:0] raw_len;
      logic [UID_CAP*8-1:0] uid_store;
      logic [2:0] taken;
   } frame_type;

   function automatic logic uid_len_ok(input logic [7:0] n, input int max_uid);
      return (n != 8'd0) && (n <= 8'(max_uid)) && (n <= 8'(UID_CAP));
   endfunction

endpackage

@@ rtl/nfctr_front.sv @@
// Front end: accepts response bytes, tracks the header and captures the frame fields.
module nfctr_front #(
   parameter int MAX_FRAME_BYTES = 32,
   parameter int MAX_UID_BYTES = 7
) (
   input  logic clock,
   input  logic reset,
   input  logic enabled,
   input  logic req_valid,
   output logic req_stall,
   input  nfctr_pkg::req_type req_payload,
   input  logic push_ready,
   output logic push_valid,
   output nfctr_pkg::frame_type push_frame
);
   import nfctr_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic d5_ff, d5_in;
   logic hf_ff, hf_in;
   logic [POS_W-1:0] hs_ff, hs_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] raw_ff, raw_in;
   logic [UID_CAP-1:0][7:0] uid_ff, uid_in;
   logic [2:0] taken_ff, taken_in;

   logic accept;
   logic keep;
   logic in_data;
   logic [POS_W-1:0] r;
   logic [POS_W-1:0] k;
   logic [POS_W-1:0] t_pos, t_hs;
   logic t_d5, t_hf;
   logic [7:0] t_count, t_raw;
   logic [UID_CAP-1:0][7:0] t_uid;
   logic [2:0] t_taken;

   assign req_stall = !push_ready;
   assign accept = req_valid && push_ready;
   assign keep = pos_ff < POS_W'(MAX_FRAME_BYTES);
   assign in_data = hf_ff && ({1'b0, pos_ff} >= ({1'b0, hs_ff} + 9'd2));
   assign r = pos_ff - hs_ff - POS_W'(2);
   assign k = r - POS_W'(6);

   always_comb begin
      t_pos = pos_ff;
      t_d5 = d5_ff;
      t_hf = hf_ff;
      t_hs = hs_ff;
      t_count = count_ff;
      t_raw = raw_ff;
      t_uid = uid_ff;
      t_taken = taken_ff;
      if (keep) begin
         if (in_data) begin
            if (r == POS_W'(0)) begin
               t_count = req_payload.resp_byte;
            end else if (r == POS_W'(5)) begin
               t_raw = req_payload.resp_byte;
            end else if (r >= POS_W'(6) && uid_len_ok(raw_ff, MAX_UID_BYTES) &&
                         {{(8 - POS_W + 1){1'b0}}, k} < {1'b0, raw_ff} &&
                         k < POS_W'(UID_CAP)) begin
               t_uid[k[2:0]] = req_payload.resp_byte;
               t_taken = k[2:0] + 3'd1;
            end
         end
         if (!hf_ff && d5_ff && req_payload.resp_byte == HDR_SECOND) begin
            t_hf = 1'b1;
            t_hs = pos_ff - POS_W'(1);
         end
         t_d5 = (req_payload.resp_byte == HDR_FIRST);
         t_pos = pos_ff + POS_W'(1);
      end
   end

   always_comb begin
      push_frame.enabled = enabled;
      push_frame.len = t_pos;
      push_frame.header_found = t_hf;
      push_frame.header_start = t_hs;
      push_frame.count_byte = t_count;
      push_frame.raw_len = t_raw;
      push_frame.uid_store = t_uid;
      push_frame.taken = t_taken;
   end

   assign push_valid = accept && req_payload.last_byte;

   always_comb begin
      pos_in = pos_ff;
      d5_in = d5_ff;
      hf_in = hf_ff;
      hs_in = hs_ff;
      count_in = count_ff;
      raw_in = raw_ff;
      uid_in = uid_ff;
      taken_in = taken_ff;
      if (accept) begin
         if (req_payload.last_byte) begin
            pos_in = '0;
            d5_in = 1'b0;
            hf_in = 1'b0;
            hs_in = '0;
            count_in = '0;
            raw_in = '0;
            uid_in = '0;
            taken_in = '0;
         end else begin
            pos_in = t_pos;
            d5_in = t_d5;
            hf_in = t_hf;
            hs_in = t_hs;
            count_in = t_count;
            raw_in = t_raw;
            uid_in = t_uid;
            taken_in = t_taken;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         d5_ff <= 1'b0;
         hf_ff <= 1'b0;
         hs_ff <= '0;
         count_ff <= '0;
         raw_ff <= '0;
         uid_ff <= '0;
         taken_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         d5_ff <= d5_in;
         hf_ff <= hf_in;
         hs_ff <= hs_in;
         count_ff <= count_in;
         raw_ff <= raw_in;
         uid_ff <= uid_in;
         taken_ff <= taken_in;
      end
   end

endmodule

@@ rtl/nfctr_queue.sv @@
// Short register queue that carries finished frame summaries from front to back.
module nfctr_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  nfctr_pkg::frame_type push_frame,
   output logic pop_valid,
   input  logic pop,
   output nfctr_pkg::frame_type pop_frame
);
   import nfctr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_frame = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

@@ rtl/nfctr_back.sv @@
// Back end: grades a frame summary into a status and holds the result transaction.
module nfctr_back #(
   parameter int MAX_UID_BYTES = 7
) (
   input  logic clock,
   input  logic reset,
   input  logic frame_valid,
   output logic frame_pop,
   input  nfctr_pkg::frame_type frame,
   output logic rsp_valid,
   input  logic rsp_stall,
   output nfctr_pkg::rsp_type rsp_payload
);
   import nfctr_pkg::*;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type graded;
   logic [POS_W:0] len_x;
   logic [POS_W:0] hs_x;

   assign len_x = {1'b0, frame.len};
   assign hs_x = {1'b0, frame.header_start};
   assign frame_pop = frame_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      graded.status = ST_OK;
      graded.tag_count = '0;
      graded.uid_length = '0;
      graded.uid_bytes = '0;
      if (!frame.enabled) begin
         graded.status = ST_DISABLED;
      end else if (frame.len < MIN_FRAME) begin
         graded.status = ST_SHORT;
      end else if (!frame.header_found || (hs_x + (POS_W+1)'(6)) > len_x) begin
         graded.status = ST_NO_HEADER;
      end else begin
         graded.tag_count = frame.count_byte;
         if (frame.count_byte == 8'd0) begin
            graded.status = ST_NO_TAG;
         end else if ((hs_x + (POS_W+1)'(7)) >= len_x) begin
            graded.status = ST_TRUNCATED;
         end else if (!uid_len_ok(frame.raw_len, MAX_UID_BYTES)) begin
            graded.status = ST_BAD_LENGTH;
         end else if ({5'd0, frame.taken} < frame.raw_len) begin
            graded.status = ST_TRUNCATED;
         end else begin
            graded.status = ST_OK;
            graded.uid_length = frame.raw_len[2:0];
            graded.uid_bytes = frame.uid_store;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (frame_pop) begin
         rsp_valid_in = 1'b1;
         rsp_in = graded;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/nfc_target_response_uid_parser_core.sv @@
// Top level of the target response parser: register, front end, queue and back end.
//
// The request channel takes one response byte per transaction, with a flag on
// the final byte of each frame. Bytes beyond MAX_FRAME_BYTES in a frame are
// dropped, but their final-byte flag still closes the frame. The block finds
// the response header, then takes the tag count, the UID length and the UID.
// One response transaction leaves for every frame: status, tag count, UID
// length and the UID bytes packed with the first byte in bits 7:0.
// A byte is accepted in every cycle while req_stall is low; the front end parses
// it in that cycle and, on the final byte, writes a frame summary into a
// two-entry queue. The back end grades the summary into the response register,
// and one frame per cycle can be sustained while the receiver does not stall.
// The enable register is sampled with each final byte. If the receiver stalls,
// the response register holds, the queue fills, and req_stall rises once the
// queue is full. Reset clears the frame state, the queue, the pending response
// and the enable register.
module nfc_target_response_uid_parser_core #(
   parameter int MAX_FRAME_BYTES = 32,
   parameter int MAX_UID_BYTES = 7
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   input  logic req_valid,
   output logic req_stall,
   input  nfctr_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output nfctr_pkg::rsp_type rsp_payload
);
   import nfctr_pkg::*;

   logic enabled_ff, enabled_in;
   logic push_valid, push_ready;
   frame_type push_frame;
   logic pop_valid, pop;
   frame_type pop_frame;

   assign enabled_in = csr_wr_en ? csr_wr_data : enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else begin
         enabled_ff <= enabled_in;
      end
   end

   nfctr_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .MAX_UID_BYTES(MAX_UID_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .enabled(enabled_ff),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .push_ready(push_ready),
      .push_valid(push_valid),
      .push_frame(push_frame)
   );

   nfctr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_frame(push_frame),
      .pop_valid(pop_valid),
      .pop(pop),
      .pop_frame(pop_frame)
   );

   nfctr_back #(
      .MAX_UID_BYTES(MAX_UID_BYTES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .frame_valid(pop_valid),
      .frame_pop(pop),
      .frame(pop_frame),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // A result with any status but success carries no UID.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |->
         rsp_payload.uid_length == 3'd0 && rsp_payload.uid_bytes == '0)
      else $error("UID present on a failed response");

   // A successful result always reports a nonzero UID length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_OK |-> rsp_payload.uid_length != 3'd0)
      else $error("Successful response with empty UID");

   // A frame summary popped from the queue shows up as a valid response next cycle.
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("Popped frame did not produce a response");

   // The front end never offers a summary that the queue cannot take.
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("Frame summary pushed into a full queue");

endmodule

@@ test/nfc_target_response_uid_parser_core_tb.sv @@
// Testbench for the target response UID parser: directed and random frames checked against a predictor.
module nfc_target_response_uid_parser_core_tb;
   import nfctr_pkg::*;

   localparam int FRAME_LIMIT = 32;
   localparam int UID_LIMIT = 7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 6;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;
   logic req_valid;
   logic req_stall;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_payload;

   nfc_target_response_uid_parser_core #(
      .MAX_FRAME_BYTES(FRAME_LIMIT),
      .MAX_UID_BYTES(UID_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   int send_idle_pct = 15;
   int recv_stall_pct = 50;
   int error_count = 0;
   int cycle_count = 0;

   logic [7:0] frame_buf[$];
   rsp_type expected_uid_reports[$];

   // Shadow of the frame parser state.
   bit enabled_shadow;
   int pos;
   bit prev_d5;
   bit hdr_found;
   int hdr_start;
   logic [7:0] cnt_byte;
   logic [7:0] len_byte;
   logic [UID_CAP*8-1:0] uid_acc;
   int uid_taken;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   function automatic bit uid_len_legal(input logic [7:0] n);
      return (n >= 8'd1) && (n <= UID_LIMIT) && (n <= UID_CAP);
   endfunction

   task automatic clear_frame_state();
      pos = 0;
      prev_d5 = 1'b0;
      hdr_found = 1'b0;
      hdr_start = 0;
      cnt_byte = '0;
      len_byte = '0;
      uid_acc = '0;
      uid_taken = 0;
   endtask

   task automatic parse_response_byte(input logic [7:0] b, input logic fin);
      int rel;
      int k;
      rsp_type rep;
      if (pos < FRAME_LIMIT) begin
         if (hdr_found && pos >= hdr_start + 2) begin
            rel = pos - (hdr_start + 2);
            if (rel == 0) begin
               cnt_byte = b;
            end else if (rel == 5) begin
               len_byte = b;
            end else if (rel >= 6 && uid_len_legal(len_byte)) begin
               k = rel - 6;
               if (k < len_byte && k < UID_CAP) begin
                  uid_acc[8*k +: 8] = b;
                  uid_taken = k + 1;
               end
            end
         end
         if (!hdr_found && prev_d5 && b == HDR_SECOND) begin
            hdr_found = 1'b1;
            hdr_start = pos - 1;
         end
         prev_d5 = (b == HDR_FIRST);
         pos = pos + 1;
      end
      if (fin) begin
         rep = '0;
         if (!enabled_shadow) begin
            rep.status = ST_DISABLED;
         end else if (pos < MIN_FRAME) begin
            rep.status = ST_SHORT;
         end else if (!hdr_found || hdr_start + 6 > pos) begin
            rep.status = ST_NO_HEADER;
         end else begin
            rep.tag_count = cnt_byte;
            if (cnt_byte == 8'd0) begin
               rep.status = ST_NO_TAG;
            end else if (hdr_start + 7 >= pos) begin
               rep.status = ST_TRUNCATED;
            end else if (!uid_len_legal(len_byte)) begin
               rep.status = ST_BAD_LENGTH;
            end else if (uid_taken < len_byte) begin
               rep.status = ST_TRUNCATED;
            end else begin
               rep.status = ST_OK;
               rep.uid_length = len_byte[2:0];
               rep.uid_bytes = uid_acc;
            end
         end
         expected_uid_reports.push_back(rep);
         clear_frame_state();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         parse_response_byte(req_payload.resp_byte, req_payload.last_byte);
      end
   end

   always @(posedge clock) begin
      rsp_type exp_rep;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_uid_reports.size() == 0) begin
            $error("response transaction with no expected report");
            error_count++;
         end else begin
            exp_rep = expected_uid_reports.pop_front();
            if (rsp_payload.status !== exp_rep.status) begin
               $error("status mismatch: expected %0d, got %0d",
                      exp_rep.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.tag_count !== exp_rep.tag_count) begin
               $error("tag_count mismatch: expected %0d, got %0d",
                      exp_rep.tag_count, rsp_payload.tag_count);
               error_count++;
            end
            if (rsp_payload.uid_length !== exp_rep.uid_length) begin
               $error("uid_length mismatch: expected %0d, got %0d",
                      exp_rep.uid_length, rsp_payload.uid_length);
               error_count++;
            end
            if (rsp_payload.uid_bytes !== exp_rep.uid_bytes) begin
               $error("uid_bytes mismatch: expected %h, got %h",
                      exp_rep.uid_bytes, rsp_payload.uid_bytes);
               error_count++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload.resp_byte = b;
      req_payload.last_byte = fin;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) begin
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_uid_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_enable(input logic v);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
      enabled_shadow = v;
   endtask

   // Lays out lead bytes, the header, the tag count, four skipped bytes, the
   // length byte and the UID bytes, then pads or cuts to the total if it is set.
   task automatic make_frame(input int lead, input logic [7:0] tags, input logic [7:0] ulen,
                             input int uid_n, input int total, input bit rand_fill);
      frame_buf = {};
      repeat (lead) frame_buf.push_back(rand_fill ? 8'($urandom_range(255)) : 8'h00);
      frame_buf.push_back(HDR_FIRST);
      frame_buf.push_back(HDR_SECOND);
      frame_buf.push_back(tags);
      repeat (4) frame_buf.push_back(8'($urandom_range(255)));
      frame_buf.push_back(ulen);
      repeat (uid_n) frame_buf.push_back(8'($urandom_range(255)));
      if (total > 0) begin
         while (frame_buf.size() < total) begin
            frame_buf.push_back(rand_fill ? 8'($urandom_range(255)) : 8'h00);
         end
         while (frame_buf.size() > total) void'(frame_buf.pop_back());
      end
   endtask

   task automatic test_disabled_frames();
      make_frame(0, 8'd1, 8'd4, 4, 0, 1'b0);
      send_frame();
      frame_buf = {8'h00};
      send_frame();
      wait_drained();
   endtask

   task automatic test_directed_frames();
      set_enable(1'b1);
      frame_buf = {8'hFF};
      send_frame();
      make_frame(0, 8'd1, 8'd1, 1, 9, 1'b0);
      send_frame();
      frame_buf = {8'h4B, 8'hD5, 8'h00, 8'h4B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame();
      make_frame(5, 8'd1, 8'd1, 1, 10, 1'b0);
      send_frame();
      make_frame(4, 8'd1, 8'd1, 1, 10, 1'b0);
      send_frame();
      make_frame(0, 8'd0, 8'd3, 3, 0, 1'b0);
      send_frame();
      make_frame(0, 8'd1, 8'd0, 0, 10, 1'b0);
      send_frame();
      make_frame(0, 8'd2, 8'd8, 7, 0, 1'b0);
      send_frame();
      make_frame(1, 8'hFF, 8'hFF, 0, 12, 1'b0);
      send_frame();
      make_frame(0, 8'd1, 8'd7, 3, 0, 1'b0);
      send_frame();
      make_frame(0, 8'd1, 8'd1, 1, 10, 1'b0);
      send_frame();
      make_frame(2, 8'd3, 8'd7, 7, 0, 1'b0);
      for (int i = 0; i < 7; i++) frame_buf[10 + i] = 8'hFF;
      send_frame();
      make_frame(1, 8'hFF, 8'd7, 7, 0, 1'b0);
      frame_buf[0] = HDR_FIRST;
      for (int i = 0; i < 7; i++) frame_buf[9 + i] = 8'h00;
      send_frame();
      make_frame(0, 8'd1, 8'd4, 4, 40, 1'b0);
      send_frame();
      make_frame(32, 8'd1, 8'd1, 1, 0, 1'b0);
      send_frame();
      make_frame(20, 8'd1, 8'd7, 7, 40, 1'b0);
      send_frame();
      wait_drained();
   endtask

   task automatic test_random_frames(input int s_pct, input int r_pct,
                                     input int min_bytes, input int min_frames);
      int sent_bytes;
      int sent_frames;
      int kind;
      int n;
      int lead;
      int uid_n;
      int natural_len;
      int total;
      int shape;
      logic [7:0] tags;
      logic [7:0] ulen;
      sent_bytes = 0;
      sent_frames = 0;
      send_idle_pct = s_pct;
      recv_stall_pct = r_pct;
      while (sent_bytes < min_bytes || sent_frames < min_frames) begin
         if ($urandom_range(99) < 5) wait_drained();
         kind = $urandom_range(99);
         if (kind < 12) begin
            frame_buf = {};
            n = $urandom_range(1, 40);
            repeat (n) begin
               if ($urandom_range(99) < 20) begin
                  frame_buf.push_back($urandom_range(1) ? HDR_FIRST : HDR_SECOND);
               end else begin
                  frame_buf.push_back(8'($urandom_range(255)));
               end
            end
         end else begin
            tags = ($urandom_range(99) < 10) ? 8'd0 : 8'($urandom_range(1, 255));
            if ($urandom_range(99) < 85) begin
               ulen = 8'($urandom_range(1, 7));
            end else begin
               ulen = $urandom_range(1) ? 8'd0 : 8'($urandom_range(8, 255));
            end
            uid_n = uid_len_legal(ulen) ? int'(ulen) : $urandom_range(0, 7);
            lead = $urandom_range(0, 6);
            natural_len = lead + 8 + uid_n;
            shape = $urandom_range(99);
            if (shape < 65) begin
               total = natural_len + $urandom_range(0, 4);
               if (total < 10) total = 10;
            end else if (shape < 85) begin
               total = $urandom_range(1, natural_len);
            end else begin
               total = $urandom_range(33, 40);
            end
            make_frame(lead, tags, ulen, uid_n, total, 1'b1);
         end
         send_frame();
         sent_bytes += frame_buf.size();
         sent_frames++;
      end
      wait_drained();
   endtask

   task automatic test_enable_toggle();
      set_enable(1'b0);
      test_random_frames(50, 15, 40, 3);
      set_enable(1'b1);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      enabled_shadow = 1'b0;
      clear_frame_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_disabled_frames();
      test_directed_frames();
      test_random_frames(15, 50, 50, 3);
      test_random_frames(50, 15, 50, 3);
      test_enable_toggle();
      test_random_frames(0, 0, 50, 3);

      if (expected_uid_reports.size() != 0) begin
         $error("%0d expected reports never arrived", expected_uid_reports.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/nfctr_pkg.sv
rtl/nfctr_front.sv
rtl/nfctr_queue.sv
rtl/nfctr_back.sv
rtl/nfc_target_response_uid_parser_core.sv
test/nfc_target_response_uid_parser_core_tb.sv
